// ----- src/cubic_bezier_stepper_top_assert.svh -----
// Assertion macros for the cubic Bezier stepper checker.
// Each macro samples on the rising edge of clock and is disabled while reset is high.
`ifndef CUBIC_BEZIER_STEPPER_TOP_ASSERT_SVH
`define CUBIC_BEZIER_STEPPER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CBS_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CBS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/cbs_pkg.sv -----
// Shared constants, types and the evaluation sequence of the cubic Bezier stepper.
// Used by the register file, the controller, the datapath and the top level.
`default_nettype none

package cbs_pkg;

   // Fixed point format of the curve parameter and the weights.
   localparam int FRAC_BITS = 16;
   localparam int T_W       = FRAC_BITS + 1;
   localparam int W_W       = FRAC_BITS + 2;
   localparam int STEP_W    = 16;
   localparam int SUM_W     = ((T_W > STEP_W) ? T_W : STEP_W) + 1;
   localparam int SM_W      = T_W + 3;

   // Point layout: three signed components packed into one register.
   localparam int COMP_W   = 16;
   localparam int NUM_COMP = 3;
   localparam int PT_W     = COMP_W * NUM_COMP;
   localparam int NUM_PTS  = 4;
   localparam int END_PT   = NUM_PTS - 1;

   // Shared multiplier and accumulator.
   localparam int MUL_W  = ((FRAC_BITS + 3) > (COMP_W + 1)) ? (FRAC_BITS + 3) : (COMP_W + 1);
   localparam int PROD_W = 2 * MUL_W;
   localparam int ACC_W  = PROD_W + 2;

   // Register port.
   localparam int DATA_W  = 64;
   localparam int ADDR_W  = 5;
   localparam int ADDR_LO = 3;

   localparam logic [T_W-1:0] ONE_T = T_W'(1) << FRAC_BITS;
   localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) << (FRAC_BITS - 1);
   localparam logic signed [ACC_W-1:0] SAT_HI   = ACC_W'((2 ** (COMP_W - 1)) - 1);
   localparam logic signed [ACC_W-1:0] SAT_LO   = ~SAT_HI;

   // Evaluation sequence length.
   localparam int SEQ_W = 5;
   localparam logic [SEQ_W-1:0] LAST_STEP = SEQ_W'(22);

   typedef logic [1:0] comp_idx_type;
   typedef logic [1:0] pt_idx_type;
   typedef logic [NUM_PTS-1:0][PT_W-1:0] pts_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_T2,
      OP_T3,
      OP_SMOOTH,
      OP_U2,
      OP_S2,
      OP_W0,
      OP_W1,
      OP_W2,
      OP_W3,
      OP_MAC
   } dp_op_type;

   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_LOAD,
      ACC_ADD
   } acc_op_type;

   typedef struct packed {
      dp_op_type    op;
      pt_idx_type   mac_k;
      comp_idx_type mac_c;
      acc_op_type   acc_op;
      logic         rnd_en;
      comp_idx_type rnd_c;
   } cbs_step_type;

   typedef struct packed {
      cbs_step_type step;
      logic         capture;
      logic         publish;
   } cbs_cmd_type;

   typedef struct packed {
      logic t_full;
   } cbs_sts_type;

   localparam cbs_step_type STEP_NOP = '{
      op: OP_NONE, mac_k: '0, mac_c: '0, acc_op: ACC_HOLD, rnd_en: 1'b0, rnd_c: '0
   };

   // One signed component of a packed point.
   function automatic logic signed [COMP_W-1:0] pt_comp(input logic [PT_W-1:0] pt,
                                                        input comp_idx_type c);
      logic signed [COMP_W-1:0] v;
      case (c)
         2'd0:    v = pt[COMP_W-1:0];
         2'd1:    v = pt[2*COMP_W-1:COMP_W];
         default: v = pt[3*COMP_W-1:2*COMP_W];
      endcase
      return v;
   endfunction

   // Command issued at each step of the evaluation. The weights are formed first,
   // then each component is accumulated from the multiplier's registered product,
   // and rounded while the next component starts.
   function automatic cbs_step_type seq_step(input logic [SEQ_W-1:0] idx);
      cbs_step_type s;
      s = STEP_NOP;
      case (idx)
         5'd0:  s.op = OP_T2;
         5'd1:  s.op = OP_T3;
         5'd2:  s.op = OP_SMOOTH;
         5'd3:  s.op = OP_U2;
         5'd4:  s.op = OP_S2;
         5'd5:  s.op = OP_W0;
         5'd6:  s.op = OP_W1;
         5'd7:  s.op = OP_W2;
         5'd8:  s.op = OP_W3;
         5'd9:  begin s.op = OP_MAC; s.mac_k = 2'd0; s.mac_c = 2'd0; end
         5'd10: begin s.op = OP_MAC; s.mac_k = 2'd1; s.mac_c = 2'd0; s.acc_op = ACC_LOAD; end
         5'd11: begin s.op = OP_MAC; s.mac_k = 2'd2; s.mac_c = 2'd0; s.acc_op = ACC_ADD; end
         5'd12: begin s.op = OP_MAC; s.mac_k = 2'd3; s.mac_c = 2'd0; s.acc_op = ACC_ADD; end
         5'd13: begin s.op = OP_MAC; s.mac_k = 2'd0; s.mac_c = 2'd1; s.acc_op = ACC_ADD; end
         5'd14: begin
            s.op = OP_MAC; s.mac_k = 2'd1; s.mac_c = 2'd1; s.acc_op = ACC_LOAD;
            s.rnd_en = 1'b1; s.rnd_c = 2'd0;
         end
         5'd15: begin s.op = OP_MAC; s.mac_k = 2'd2; s.mac_c = 2'd1; s.acc_op = ACC_ADD; end
         5'd16: begin s.op = OP_MAC; s.mac_k = 2'd3; s.mac_c = 2'd1; s.acc_op = ACC_ADD; end
         5'd17: begin s.op = OP_MAC; s.mac_k = 2'd0; s.mac_c = 2'd2; s.acc_op = ACC_ADD; end
         5'd18: begin
            s.op = OP_MAC; s.mac_k = 2'd1; s.mac_c = 2'd2; s.acc_op = ACC_LOAD;
            s.rnd_en = 1'b1; s.rnd_c = 2'd1;
         end
         5'd19: begin s.op = OP_MAC; s.mac_k = 2'd2; s.mac_c = 2'd2; s.acc_op = ACC_ADD; end
         5'd20: begin s.op = OP_MAC; s.mac_k = 2'd3; s.mac_c = 2'd2; s.acc_op = ACC_ADD; end
         5'd21: s.acc_op = ACC_ADD;
         5'd22: begin s.rnd_en = 1'b1; s.rnd_c = 2'd2; end
         default: s = STEP_NOP;
      endcase
      return s;
   endfunction

endpackage

`default_nettype wire

// ----- src/cbs_csr.sv -----
// Register file holding the four control points of the curve.
// Depends on cbs_pkg for the point layout and the port widths.
`default_nettype none

module cbs_csr (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         psel,
   input  wire logic                         penable,
   input  wire logic                         pwrite,
   input  wire logic [cbs_pkg::ADDR_W-1:0]   paddr,
   input  wire logic [cbs_pkg::DATA_W-1:0]   pwdata,
   output logic      [cbs_pkg::DATA_W-1:0]   prdata,
   output logic                              pready,
   output cbs_pkg::pts_type                  pts
);

   cbs_pkg::pts_type    pts_ff;
   cbs_pkg::pt_idx_type reg_idx;

   assign reg_idx = paddr[cbs_pkg::ADDR_W-1:cbs_pkg::ADDR_LO];

   always_ff @(posedge clock) begin
      if (reset) begin
         pts_ff <= '0;
      end else if (psel && penable && pwrite) begin
         pts_ff[reg_idx] <= pwdata[cbs_pkg::PT_W-1:0];
      end
   end

   assign prdata = cbs_pkg::DATA_W'(pts_ff[reg_idx]);
   assign pready = 1'b1;
   assign pts    = pts_ff;

endmodule

`default_nettype wire

// ----- src/cbs_ctrl.sv -----
// Controller of the stepper: handshakes, evaluation sequencer and result slot.
// Depends on cbs_pkg for the command, status and sequence definitions.
`default_nettype none

module cbs_ctrl (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   input  wire cbs_pkg::cbs_sts_type sts,
   output cbs_pkg::cbs_cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_FIN
   } state_type;

   state_type                    state_ff;
   logic [cbs_pkg::SEQ_W-1:0]    step_idx_ff;
   cbs_pkg::cbs_step_type        step_ff;
   logic                         out_valid_ff;
   logic                         accept;
   logic                         publish;

   assign req_ready = (state_ff == ST_IDLE) && !reset;
   assign accept    = req_valid && req_ready;
   assign publish   = (state_ff == ST_FIN) && (!out_valid_ff || rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_idx_ff  <= '0;
         step_ff      <= cbs_pkg::STEP_NOP;
         out_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  if (sts.t_full) begin
                     state_ff <= ST_FIN;
                  end else begin
                     state_ff    <= ST_RUN;
                     step_idx_ff <= '0;
                     step_ff     <= cbs_pkg::seq_step('0);
                  end
               end
            end
            ST_RUN: begin
               if (step_idx_ff == cbs_pkg::LAST_STEP) begin
                  state_ff <= ST_FIN;
                  step_ff  <= cbs_pkg::STEP_NOP;
               end else begin
                  step_idx_ff <= step_idx_ff + cbs_pkg::SEQ_W'(1);
                  step_ff     <= cbs_pkg::seq_step(step_idx_ff + cbs_pkg::SEQ_W'(1));
               end
            end
            ST_FIN: begin
               if (publish) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase

         if (publish) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = out_valid_ff;
   assign cmd = '{step: step_ff, capture: accept, publish: publish};

endmodule

`default_nettype wire

// ----- src/cbs_dp.sv -----
// Datapath of the stepper: curve parameter, shared multiplier, weights and accumulator.
// Depends on cbs_pkg; driven step by step by the controller.
`default_nettype none

module cbs_dp (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire cbs_pkg::cbs_cmd_type               cmd,
   input  wire cbs_pkg::pts_type                   pts,
   input  wire logic [cbs_pkg::STEP_W-1:0]         req_step_size,
   input  wire logic                               req_smooth,
   output cbs_pkg::cbs_sts_type                    sts,
   output logic signed [cbs_pkg::COMP_W-1:0]       rsp_pos_x,
   output logic signed [cbs_pkg::COMP_W-1:0]       rsp_pos_y,
   output logic signed [cbs_pkg::COMP_W-1:0]       rsp_pos_z,
   output logic                                    rsp_done_res
);

   logic [cbs_pkg::T_W-1:0]                        t_ff;
   logic [cbs_pkg::T_W-1:0]                        s_ff;
   logic                                           smooth_ff;
   logic [cbs_pkg::T_W-1:0]                        t2_ff;
   logic [cbs_pkg::T_W-1:0]                        t3_ff;
   logic [cbs_pkg::T_W-1:0]                        u2_ff;
   logic [cbs_pkg::T_W-1:0]                        s2_ff;
   logic [cbs_pkg::NUM_PTS-1:0][cbs_pkg::W_W-1:0]  w_ff;
   logic signed [cbs_pkg::PROD_W-1:0]              prod_ff;
   logic signed [cbs_pkg::ACC_W-1:0]               acc_ff;
   logic [cbs_pkg::NUM_COMP-1:0][cbs_pkg::COMP_W-1:0] res_ff;
   logic                                           res_done_ff;
   logic signed [cbs_pkg::COMP_W-1:0]              pos_x_ff;
   logic signed [cbs_pkg::COMP_W-1:0]              pos_y_ff;
   logic signed [cbs_pkg::COMP_W-1:0]              pos_z_ff;
   logic                                           done_ff;

   logic                                           t_full;
   logic [cbs_pkg::SUM_W-1:0]                      t_sum;
   logic [cbs_pkg::T_W-1:0]                        t_next;
   logic [cbs_pkg::T_W-1:0]                        u_val;
   logic [cbs_pkg::SM_W-1:0]                       sm_val;
   logic [cbs_pkg::T_W-1:0]                        sm_clamped;
   logic signed [cbs_pkg::MUL_W-1:0]               mul_a;
   logic signed [cbs_pkg::MUL_W-1:0]               mul_b;
   logic signed [cbs_pkg::PROD_W-1:0]              product;
   logic [cbs_pkg::T_W-1:0]                        prod_q;
   logic [cbs_pkg::W_W-1:0]                        prod_q3;
   logic signed [cbs_pkg::ACC_W-1:0]               rnd_val;
   logic signed [cbs_pkg::ACC_W-1:0]               rnd_sh;
   logic [cbs_pkg::COMP_W-1:0]                     sat_val;

   assign t_full  = (t_ff == cbs_pkg::ONE_T);
   assign sts     = '{t_full: t_full};

   // The parameter saturates at one.
   assign t_sum  = cbs_pkg::SUM_W'(t_ff) + cbs_pkg::SUM_W'(req_step_size);
   assign t_next = (t_sum > cbs_pkg::SUM_W'(cbs_pkg::ONE_T)) ?
                   cbs_pkg::ONE_T : t_sum[cbs_pkg::T_W-1:0];

   assign u_val = cbs_pkg::ONE_T - s_ff;

   // Smoothstep 3t^2 - 2t^3, never negative since t3 <= t2; clamped at one.
   assign sm_val = (cbs_pkg::SM_W'(t2_ff) << 1) + cbs_pkg::SM_W'(t2_ff)
                 - (cbs_pkg::SM_W'(t3_ff) << 1);
   assign sm_clamped = (sm_val > cbs_pkg::SM_W'(cbs_pkg::ONE_T)) ?
                       cbs_pkg::ONE_T : sm_val[cbs_pkg::T_W-1:0];

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.step.op)
         cbs_pkg::OP_T2: begin
            mul_a = cbs_pkg::MUL_W'(t_ff);
            mul_b = cbs_pkg::MUL_W'(t_ff);
         end
         cbs_pkg::OP_T3: begin
            mul_a = cbs_pkg::MUL_W'(t2_ff);
            mul_b = cbs_pkg::MUL_W'(t_ff);
         end
         cbs_pkg::OP_U2: begin
            mul_a = cbs_pkg::MUL_W'(u_val);
            mul_b = cbs_pkg::MUL_W'(u_val);
         end
         cbs_pkg::OP_S2: begin
            mul_a = cbs_pkg::MUL_W'(s_ff);
            mul_b = cbs_pkg::MUL_W'(s_ff);
         end
         cbs_pkg::OP_W0: begin
            mul_a = cbs_pkg::MUL_W'(u2_ff);
            mul_b = cbs_pkg::MUL_W'(u_val);
         end
         cbs_pkg::OP_W1: begin
            mul_a = cbs_pkg::MUL_W'(u2_ff);
            mul_b = cbs_pkg::MUL_W'(s_ff);
         end
         cbs_pkg::OP_W2: begin
            mul_a = cbs_pkg::MUL_W'(u_val);
            mul_b = cbs_pkg::MUL_W'(s2_ff);
         end
         cbs_pkg::OP_W3: begin
            mul_a = cbs_pkg::MUL_W'(s2_ff);
            mul_b = cbs_pkg::MUL_W'(s_ff);
         end
         cbs_pkg::OP_MAC: begin
            mul_a = cbs_pkg::MUL_W'(w_ff[cmd.step.mac_k]);
            mul_b = cbs_pkg::MUL_W'(cbs_pkg::pt_comp(pts[cmd.step.mac_k], cmd.step.mac_c));
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign product = mul_a * mul_b;
   assign prod_q  = product[2*cbs_pkg::FRAC_BITS:cbs_pkg::FRAC_BITS];
   assign prod_q3 = (cbs_pkg::W_W'(prod_q) << 1) + cbs_pkg::W_W'(prod_q);

   // Round to nearest with ties upward, then saturate to the component range.
   assign rnd_val = acc_ff + cbs_pkg::RND_HALF;
   assign rnd_sh  = rnd_val >>> cbs_pkg::FRAC_BITS;
   assign sat_val = (rnd_sh > cbs_pkg::SAT_HI) ? cbs_pkg::SAT_HI[cbs_pkg::COMP_W-1:0] :
                    (rnd_sh < cbs_pkg::SAT_LO) ? cbs_pkg::SAT_LO[cbs_pkg::COMP_W-1:0] :
                                                 rnd_sh[cbs_pkg::COMP_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         t_ff <= '0;
      end else if (cmd.capture && !t_full) begin
         t_ff <= t_next;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         if (t_full) begin
            res_ff[0]   <= cbs_pkg::pt_comp(pts[cbs_pkg::END_PT], 2'd0);
            res_ff[1]   <= cbs_pkg::pt_comp(pts[cbs_pkg::END_PT], 2'd1);
            res_ff[2]   <= cbs_pkg::pt_comp(pts[cbs_pkg::END_PT], 2'd2);
            res_done_ff <= 1'b1;
         end else begin
            s_ff        <= t_next;
            smooth_ff   <= req_smooth;
            res_done_ff <= 1'b0;
         end
      end

      case (cmd.step.op)
         cbs_pkg::OP_T2:     t2_ff <= prod_q;
         cbs_pkg::OP_T3:     t3_ff <= prod_q;
         cbs_pkg::OP_SMOOTH: begin
            if (smooth_ff) begin
               s_ff <= sm_clamped;
            end
         end
         cbs_pkg::OP_U2:     u2_ff <= prod_q;
         cbs_pkg::OP_S2:     s2_ff <= prod_q;
         cbs_pkg::OP_W0:     w_ff[0] <= cbs_pkg::W_W'(prod_q);
         cbs_pkg::OP_W1:     w_ff[1] <= prod_q3;
         cbs_pkg::OP_W2:     w_ff[2] <= prod_q3;
         cbs_pkg::OP_W3:     w_ff[3] <= cbs_pkg::W_W'(prod_q);
         cbs_pkg::OP_MAC:    prod_ff <= product;
         default: ;
      endcase

      unique case (cmd.step.acc_op)
         cbs_pkg::ACC_HOLD: ;
         cbs_pkg::ACC_LOAD: acc_ff <= cbs_pkg::ACC_W'(prod_ff);
         cbs_pkg::ACC_ADD:  acc_ff <= acc_ff + cbs_pkg::ACC_W'(prod_ff);
         default: ;
      endcase

      if (cmd.step.rnd_en) begin
         case (cmd.step.rnd_c)
            2'd0:    res_ff[0] <= sat_val;
            2'd1:    res_ff[1] <= sat_val;
            default: res_ff[2] <= sat_val;
         endcase
      end

      if (cmd.publish) begin
         pos_x_ff <= res_ff[0];
         pos_y_ff <= res_ff[1];
         pos_z_ff <= res_ff[2];
         done_ff  <= res_done_ff;
      end
   end

   assign rsp_pos_x    = pos_x_ff;
   assign rsp_pos_y    = pos_y_ff;
   assign rsp_pos_z    = pos_z_ff;
   assign rsp_done_res = done_ff;

endmodule

`default_nettype wire

// ----- src/cubic_bezier_stepper_top.sv -----
// Cubic Bezier stepper. Every transfer on the request channel advances the curve parameter t
// by req_step_size (a fraction of the curve in units of 2^-16), saturating at one, and returns
// one point on the response channel: the curve evaluated at t, or at the smoothstep of t when
// req_smooth is set. Once t has already reached one, a request returns the end point unchanged
// with rsp_done_res high; only reset brings t back to zero. The four control points live in
// 64-bit registers at byte addresses 0, 8, 16 and 24 (start, first control, second control,
// end), each holding x, y and z as signed 16-bit values in bits 15:0, 31:16 and 47:32. Write
// them only while no request is in flight. One request is worked on at a time: an evaluated
// point passes from its request transfer through the accept, the 23 steps of the sequence that
// shares a single multiplier between the Bernstein weights and the twelve point products, and
// the hand-off of the point to the response register, which waits while an earlier point is
// still held and not taken. A request made after t reached one skips the sequence. The response
// register lets the next request start while the previous point still waits to be taken.
// Depends on cbs_pkg, cbs_csr, cbs_ctrl and cbs_dp.
`default_nettype none

module cubic_bezier_stepper_top (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // Request channel.
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [cbs_pkg::STEP_W-1:0]     req_step_size,
   input  wire logic                           req_smooth,
   // Response channel.
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic signed [cbs_pkg::COMP_W-1:0]   rsp_pos_x,
   output logic signed [cbs_pkg::COMP_W-1:0]   rsp_pos_y,
   output logic signed [cbs_pkg::COMP_W-1:0]   rsp_pos_z,
   output logic                                rsp_done_res,
   // Register port.
   input  wire logic                           psel,
   input  wire logic                           penable,
   input  wire logic                           pwrite,
   input  wire logic [cbs_pkg::ADDR_W-1:0]     paddr,
   input  wire logic [cbs_pkg::DATA_W-1:0]     pwdata,
   output logic      [cbs_pkg::DATA_W-1:0]     prdata,
   output logic                                pready
);

   // The controller drives the datapath one step per cycle; the datapath only reports
   // whether the parameter already sits at one.
   cbs_pkg::cbs_cmd_type cmd;
   cbs_pkg::cbs_sts_type sts;
   cbs_pkg::pts_type     pts;

   cbs_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .pts     (pts)
   );

   cbs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   cbs_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .pts           (pts),
      .req_step_size (req_step_size),
      .req_smooth    (req_smooth),
      .sts           (sts),
      .rsp_pos_x     (rsp_pos_x),
      .rsp_pos_y     (rsp_pos_y),
      .rsp_pos_z     (rsp_pos_z),
      .rsp_done_res  (rsp_done_res)
   );

endmodule

`default_nettype wire

// ----- src/cbs_chk.sv -----
// Port-level checker for the cubic Bezier stepper, bound to the top level.
// Depends on cbs_pkg and the assertion macros in cubic_bezier_stepper_top_assert.svh.
`default_nettype none
`include "cubic_bezier_stepper_top_assert.svh"

module cbs_chk (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_valid,
   input wire logic                           req_ready,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_ready,
   input wire logic signed [cbs_pkg::COMP_W-1:0] rsp_pos_x,
   input wire logic signed [cbs_pkg::COMP_W-1:0] rsp_pos_y,
   input wire logic signed [cbs_pkg::COMP_W-1:0] rsp_pos_z,
   input wire logic                           rsp_done_res
);

   logic [3*cbs_pkg::COMP_W:0] rsp_data;

   assign rsp_data = {rsp_pos_x, rsp_pos_y, rsp_pos_z, rsp_done_res};

   // A stalled response keeps its point and flag.
   `CBS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "stalled response changed")

   // Only one request is worked on at a time.
   `CBS_ASSERT_NEXT(a_one_in_flight, req_valid && req_ready, !req_ready, "second request accepted")

   // No request can produce its response in the cycle right after its transfer.
   `CBS_ASSERT_NEXT(a_no_instant_rsp, req_valid && req_ready, !$rose(rsp_valid), "response too early")

endmodule

bind cubic_bezier_stepper_top cbs_chk u_cbs_chk (.*);

`default_nettype wire
